// ===== rtl/dis_pkg.sv =====
// Shared constants and types of the disjoint interval set.
package dis_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic KIND_ADD     = 1'b0;
   localparam logic KIND_READOUT = 1'b1;

   typedef enum logic [2:0] {
      ST_NEW      = 3'd0,
      ST_EXTEND   = 3'd1,
      ST_JOIN     = 3'd2,
      ST_COVERED  = 3'd3,
      ST_FULL     = 3'd4,
      ST_READOUT  = 3'd5
   } status_type;

endpackage

// ===== rtl/dis_req_if.sv =====
// Request channel: one beat carries a command kind and a value.
interface dis_req_if import dis_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== rtl/dis_rsp_if.sv =====
// Response channel: one beat carries a status and optionally one interval.
interface dis_rsp_if import dis_pkg::*; ();
   logic                     valid;
   logic                     ready;
   status_type               add_status;
   logic signed [DATA_W-1:0] interval_start;
   logic signed [DATA_W-1:0] interval_end;
   logic                     has_interval;
   logic                     last;

   modport source (output valid, output add_status, output interval_start,
                   output interval_end, output has_interval, output last,
                   input ready);
   modport sink   (input valid, input add_status, input interval_start,
                   input interval_end, input has_interval, input last,
                   output ready);
endinterface

// ===== rtl/dis_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/disjoint_interval_set_top.sv =====
// Flow: an add scans the stored intervals (RAM read, then compare) up to the first one above the value,
//   decides, moves entries when a new interval is inserted or two are joined, places a new
//   interval if one is inserted, and emits the response beat.
// A readout reads each stored interval (RAM read, then response beat); empty: a single beat with no interval.
// Throughput: one request at a time, one shared subtractor; a held response beat stalls.
// Reset clears the interval count and the control state; no RAM clearing pass is needed.
module disjoint_interval_set_top import dis_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   dis_req_if.sink   req,
   dis_rsp_if.source rsp
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DECIDE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_RO_RD,
      S_RO_OUT,
      S_EMIT
   } state_type;

   state_type                state_ff;
   logic [CNT_W-1:0]         count_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [CNT_W-1:0]         ptr_ff;     // scan index and RAM read address
   logic [CNT_W-1:0]         dst_ff;     // write target while moving entries
   logic [CNT_W-1:0]         idx_ff;     // first entry that starts above the value
   logic                     shift_up_ff;
   logic signed [DATA_W-1:0] prev_end_ff;
   logic signed [DATA_W-1:0] above_end_ff;
   logic                     has_below_ff;
   logic                     has_above_ff;
   logic                     touch_above_ff;
   status_type               status_ff;

   // response register
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_start_ff;
   logic signed [DATA_W-1:0] rsp_end_ff;
   logic                     rsp_has_ff;
   logic                     rsp_last_ff;

   // table RAM ports
   logic                     start_we;
   logic                     end_we;
   logic [IDX_W-1:0]         wr_addr;
   logic [DATA_W-1:0]        start_wd;
   logic [DATA_W-1:0]        end_wd;
   logic [DATA_W-1:0]        start_rd;
   logic [DATA_W-1:0]        end_rd;

   // shared subtractor: operand minus value, widened so limits never wrap
   logic signed [DATA_W-1:0] sub_op;
   logic signed [DATA_W+1:0] diff;
   logic                     diff_pos;
   logic                     diff_nonneg;
   logic                     diff_one;
   logic                     diff_minus_one;

   logic                     out_free;
   logic                     rsp_load;
   logic                     covered;
   logic                     touch_below;
   logic                     touch_above;
   logic [CNT_W-1:0]         idx_m1;

   dis_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_start_ram (
      .clock   (clock),
      .wr_en   (start_we),
      .wr_addr (wr_addr),
      .wr_data (start_wd),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (start_rd)
   );

   dis_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_end_ram (
      .clock   (clock),
      .wr_en   (end_we),
      .wr_addr (wr_addr),
      .wr_data (end_wd),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (end_rd)
   );

   // Compare the candidate start while scanning, the end below while deciding.
   assign sub_op = (state_ff == S_SCAN_CMP) ? $signed(start_rd) : prev_end_ff;
   assign diff   = {{2{sub_op[DATA_W-1]}}, sub_op} - {{2{value_ff[DATA_W-1]}}, value_ff};

   assign diff_nonneg    = !diff[DATA_W+1];
   assign diff_pos       = diff_nonneg && (diff != '0);
   assign diff_one       = (diff == (DATA_W+2)'(1));
   assign diff_minus_one = (diff == '1);

   assign covered     = has_below_ff && diff_nonneg;
   assign touch_below = has_below_ff && diff_minus_one;
   assign touch_above = has_above_ff && touch_above_ff;
   assign idx_m1      = idx_ff - CNT_W'(1);

   assign out_free  = !rsp_valid_ff || rsp.ready;
   // a new beat goes into the response register this cycle
   assign rsp_load  = out_free && (state_ff == S_RO_OUT || state_ff == S_EMIT);
   assign req.ready = (state_ff == S_IDLE);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.add_status     = rsp_status_ff;
   assign rsp.interval_start = rsp_start_ff;
   assign rsp.interval_end   = rsp_end_ff;
   assign rsp.has_interval   = rsp_has_ff;
   assign rsp.last           = rsp_last_ff;

   // Table writes: grow or join at the decision, move entries, drop in the new one.
   always_comb begin
      start_we = 1'b0;
      end_we   = 1'b0;
      wr_addr  = idx_ff[IDX_W-1:0];
      start_wd = value_ff;
      end_wd   = value_ff;
      if (state_ff == S_DECIDE && !covered) begin
         if (touch_below && touch_above) begin
            end_we  = 1'b1;
            wr_addr = idx_m1[IDX_W-1:0];
            end_wd  = above_end_ff;
         end else if (touch_below) begin
            end_we  = 1'b1;
            wr_addr = idx_m1[IDX_W-1:0];
         end else if (touch_above) begin
            start_we = 1'b1;
         end
      end else if (state_ff == S_SHIFT_WR) begin
         start_we = 1'b1;
         end_we   = 1'b1;
         wr_addr  = dst_ff[IDX_W-1:0];
         start_wd = start_rd;
         end_wd   = end_rd;
      end else if (state_ff == S_PLACE) begin
         start_we = 1'b1;
         end_we   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // load a new beat, or drop the current one once taken
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  value_ff     <= req.value;
                  ptr_ff       <= '0;
                  has_below_ff <= 1'b0;
                  has_above_ff <= 1'b0;
                  if (req.kind == KIND_ADD) begin
                     state_ff <= S_SCAN_RD;
                  end else if (count_ff == '0) begin
                     status_ff <= ST_READOUT;
                     state_ff  <= S_EMIT;
                  end else begin
                     state_ff <= S_RO_RD;
                  end
               end
            end

            S_SCAN_RD: begin
               // past the last entry: nothing above the value
               if (ptr_ff == count_ff) begin
                  idx_ff   <= count_ff;
                  state_ff <= S_DECIDE;
               end else begin
                  state_ff <= S_SCAN_CMP;
               end
            end

            S_SCAN_CMP: begin
               if (diff_pos) begin
                  idx_ff         <= ptr_ff;
                  has_above_ff   <= 1'b1;
                  touch_above_ff <= diff_one;
                  above_end_ff   <= end_rd;
                  state_ff       <= S_DECIDE;
               end else begin
                  prev_end_ff  <= end_rd;
                  has_below_ff <= 1'b1;
                  ptr_ff       <= ptr_ff + CNT_W'(1);
                  state_ff     <= S_SCAN_RD;
               end
            end

            S_DECIDE: begin
               priority if (covered) begin
                  status_ff <= ST_COVERED;
                  state_ff  <= S_EMIT;
               end else if (touch_below && touch_above) begin
                  // close the gap: move entries above the joined one down by one
                  dst_ff      <= idx_ff;
                  ptr_ff      <= idx_ff + CNT_W'(1);
                  shift_up_ff <= 1'b1;
                  state_ff    <= S_SHIFT_RD;
               end else if (touch_below || touch_above) begin
                  status_ff <= ST_EXTEND;
                  state_ff  <= S_EMIT;
               end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  status_ff <= ST_FULL;
                  state_ff  <= S_EMIT;
               end else begin
                  // open a slot: move entries from the top down to the insert point
                  dst_ff      <= count_ff;
                  ptr_ff      <= count_ff - CNT_W'(1);
                  shift_up_ff <= 1'b0;
                  state_ff    <= S_SHIFT_RD;
               end
            end

            S_SHIFT_RD: begin
               if (shift_up_ff && ptr_ff == count_ff) begin
                  count_ff  <= count_ff - CNT_W'(1);
                  status_ff <= ST_JOIN;
                  state_ff  <= S_EMIT;
               end else if (!shift_up_ff && dst_ff == idx_ff) begin
                  state_ff <= S_PLACE;
               end else begin
                  state_ff <= S_SHIFT_WR;
               end
            end

            S_SHIFT_WR: begin
               dst_ff   <= ptr_ff;
               ptr_ff   <= shift_up_ff ? ptr_ff + CNT_W'(1) : ptr_ff - CNT_W'(1);
               state_ff <= S_SHIFT_RD;
            end

            S_PLACE: begin
               count_ff  <= count_ff + CNT_W'(1);
               status_ff <= ST_NEW;
               state_ff  <= S_EMIT;
            end

            S_RO_RD: begin
               state_ff <= S_RO_OUT;
            end

            S_RO_OUT: begin
               // hold the read data until the response register frees up
               if (out_free) begin
                  rsp_status_ff <= ST_READOUT;
                  rsp_start_ff  <= start_rd;
                  rsp_end_ff    <= end_rd;
                  rsp_has_ff    <= 1'b1;
                  rsp_last_ff   <= (ptr_ff + CNT_W'(1) == count_ff);
                  if (ptr_ff + CNT_W'(1) == count_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ptr_ff   <= ptr_ff + CNT_W'(1);
                     state_ff <= S_RO_RD;
                  end
               end
            end

            S_EMIT: begin
               if (out_free) begin
                  rsp_status_ff <= status_ff;
                  rsp_start_ff  <= '0;
                  rsp_end_ff    <= '0;
                  rsp_has_ff    <= 1'b0;
                  rsp_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("interval count above table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + CNT_W'(1)) ||
                             (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("interval count moved by more than one");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_has_ff |-> rsp_last_ff)
      else $error("beat without interval is not the last one");

   a_interval_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_has_ff |-> rsp_status_ff == ST_READOUT)
      else $error("interval beat with non-readout status");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !start_we && !end_we)
      else $error("table written while idle");

endmodule
